// ----- src/ppsa_pkg.sv -----
package ppsa_pkg;

  // Field widths fixed by the request and result formats
  localparam int OP_W     = 3;
  localparam int ADDR_W   = 32;
  localparam int CNT13_W  = 13;
  localparam int STATUS_W = 2;
  localparam int PAGE_SH  = 12;
  localparam int FRAME20  = ADDR_W - PAGE_SH;
  localparam int PAGES_W  = FRAME20 + 1;

  // Opcodes
  localparam logic [OP_W-1:0] OP_GET     = 3'd0;
  localparam logic [OP_W-1:0] OP_PUT     = 3'd1;
  localparam logic [OP_W-1:0] OP_RESERVE = 3'd2;
  localparam logic [OP_W-1:0] OP_GETRES  = 3'd3;
  localparam logic [OP_W-1:0] OP_REGION  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STS_DROP  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic pop_emit;
    logic walk;
  } ppsa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pop_go;
    logic walk_go;
    logic walk_done;
  } ppsa_sts_t;

endpackage

// ----- src/ppsa_ctrl.sv -----
module ppsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ppsa_pkg::ppsa_sts_t sts,
  output logic                busy,
  output ppsa_pkg::ppsa_cmd_t cmd
);
  import ppsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_POP  = 4'b0100,
    S_WALK = 4'b1000
  } ppsa_state_t;

  ppsa_state_t state_r, state_nxt;

  // Sequence one request: decode, optional memory read, optional page walk
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.pop_go) begin
          state_nxt = S_POP;
        end else if (sts.walk_go) begin
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        cmd.pop_emit = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A pop always goes back to idle right after its read
  a_pop_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |=> state_r == S_IDLE)
    else $error("pop state did not return to idle");

  // Accepting a request always leads into decode
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> state_r == S_EXEC)
    else $error("accepted request not decoded");

  // A walk only starts from decode
  a_walk_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_WALK) |-> $past(state_r == S_EXEC))
    else $error("walk entered from wrong state");

endmodule

// ----- src/ppsa_dp.sv -----
module ppsa_dp #(
  parameter int STACK_DEPTH = 4096,
  parameter int FRAME_BITS  = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ppsa_pkg::ppsa_cmd_t               cmd,
  output ppsa_pkg::ppsa_sts_t               sts,
  input  logic [ppsa_pkg::OP_W-1:0]         in_opcode,
  input  logic [ppsa_pkg::ADDR_W-1:0]       in_address,
  input  logic [ppsa_pkg::ADDR_W-1:0]       in_region_bytes,
  input  logic [ppsa_pkg::CNT13_W-1:0]      in_least_pages,
  input  logic [ppsa_pkg::CNT13_W-1:0]      in_ideal_pages,
  input  logic [ppsa_pkg::CNT13_W-1:0]      in_caller_count,
  output logic                              out_valid,
  output logic [ppsa_pkg::STATUS_W-1:0]     out_status,
  output logic [ppsa_pkg::ADDR_W-1:0]       out_page_address,
  output logic [ppsa_pkg::CNT13_W-1:0]      out_caller_count_out,
  output logic [ppsa_pkg::CNT13_W-1:0]      out_free_pages,
  output logic [ppsa_pkg::CNT13_W-1:0]      out_reserved_pages,
  output logic [ppsa_pkg::ADDR_W-1:0]       out_dropped_pages
);
  import ppsa_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int WW = ((CW > CNT13_W) ? CW : CNT13_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [ADDR_W:0] TOP_4G = {1'b1, {ADDR_W{1'b0}}};
  localparam logic [ADDR_W:0] PG_M1  = (ADDR_W + 1)'((1 << PAGE_SH) - 1);

  // Saturating add onto the 32-bit dropped counter
  function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                input logic [PAGES_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + (ADDR_W + 1)'(b);
    return s[ADDR_W] ? {ADDR_W{1'b1}} : s[ADDR_W-1:0];
  endfunction

  // Page stack memory
  logic [FRAME_BITS-1:0] mem [STACK_DEPTH];
  logic [FRAME_BITS-1:0] rdata_r;

  // Latched request
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ADDR_W-1:0]  len_r, len_nxt;
  logic [CNT13_W-1:0] least_r, least_nxt;
  logic [CNT13_W-1:0] ideal_r, ideal_nxt;
  logic [CNT13_W-1:0] caller_r, caller_nxt;

  // Allocator state
  logic [CW-1:0]      used_r, used_nxt;
  logic [CW-1:0]      resv_r, resv_nxt;
  logic [ADDR_W-1:0]  dropped_r, dropped_nxt;
  logic [PAGES_W-1:0] pages_r, pages_nxt;
  logic [FRAME20-1:0] pos_r, pos_nxt;

  // Result registers
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [ADDR_W-1:0]   page_r;
  logic [CNT13_W-1:0]  caller_out_r;
  logic [CNT13_W-1:0]  free_r;
  logic [CNT13_W-1:0]  resv_out_r;
  logic [ADDR_W-1:0]   dropped_out_r;

  // Datapath intermediates
  logic [CW-1:0]       avail;
  logic                full;
  logic [CW-1:0]       used_m1;
  logic                mem_we;
  logic [FRAME20-1:0]  wr_frame;
  logic [FRAME_BITS+FRAME20-1:0] wr_ext;
  logic [FRAME_BITS+FRAME20-1:0] rd_ext;
  logic [ADDR_W-1:0]   rd_page;
  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic [ADDR_W-1:0]   emit_page;
  logic [WW-1:0]       avail_w, least_w, want_w, grant_w, csum_w;
  logic [CNT13_W-1:0]  want;
  logic                getres_ok;
  logic [ADDR_W:0]     start_w, start_a, end_w, end_c, end_a, span;
  logic                region_ne;
  logic [CW-1:0]       free_c;
  logic [CW+CNT13_W-1:0] free_ext, resv_ext;

  assign avail   = used_r - resv_r;
  assign full    = (used_r >= DEPTH_C);
  assign used_m1 = used_r - 1'b1;

  // Frame adaption between the 20-bit page number and the stored width
  assign wr_ext  = {{FRAME_BITS{1'b0}}, wr_frame};
  assign rd_ext  = {{FRAME20{1'b0}}, rdata_r};
  assign rd_page = {rd_ext[FRAME20-1:0], {PAGE_SH{1'b0}}};

  // Reservation grant
  assign avail_w = WW'(avail);
  assign least_w = WW'(least_r);
  assign want    = (ideal_r < least_r) ? least_r : ideal_r;
  assign want_w  = WW'(want);
  assign grant_w = (want_w < avail_w) ? want_w : avail_w;
  assign csum_w  = WW'(caller_r) + grant_w;

  assign getres_ok = (caller_r != '0) && (resv_r != '0) && (used_r != '0);

  // Region bounds: start aligned up, end clipped at 4 GiB and aligned down
  assign start_w   = {1'b0, addr_r} + PG_M1;
  assign start_a   = start_w & ~PG_M1;
  assign end_w     = {1'b0, addr_r} + {1'b0, len_r};
  assign end_c     = (end_w > TOP_4G) ? TOP_4G : end_w;
  assign end_a     = end_c & ~PG_M1;
  assign region_ne = (end_a > start_a);
  assign span      = end_a - start_a;

  // Status to the controller
  assign sts.pop_go    = ((op_r == OP_GET) && (avail != '0)) ||
                         ((op_r == OP_GETRES) && getres_ok);
  assign sts.walk_go   = (op_r == OP_REGION) && region_ne;
  assign sts.walk_done = (pages_r == '0) || full;

  // Next-state logic for every command
  always_comb begin
    op_nxt      = op_r;
    addr_nxt    = addr_r;
    len_nxt     = len_r;
    least_nxt   = least_r;
    ideal_nxt   = ideal_r;
    caller_nxt  = caller_r;
    used_nxt    = used_r;
    resv_nxt    = resv_r;
    dropped_nxt = dropped_r;
    pages_nxt   = pages_r;
    pos_nxt     = pos_r;
    mem_we      = 1'b0;
    wr_frame    = addr_r[ADDR_W-1:PAGE_SH];
    emit        = 1'b0;
    emit_status = STS_OK;
    emit_page   = '0;

    if (cmd.load) begin
      op_nxt     = in_opcode;
      addr_nxt   = in_address;
      len_nxt    = in_region_bytes;
      least_nxt  = in_least_pages;
      ideal_nxt  = in_ideal_pages;
      caller_nxt = in_caller_count;
    end

    if (cmd.exec) begin
      case (op_r)
        OP_GET: begin
          if (avail == '0) begin
            emit        = 1'b1;
            emit_status = STS_EMPTY;
          end else begin
            used_nxt = used_m1;
          end
        end
        OP_PUT: begin
          emit = 1'b1;
          if (full) begin
            dropped_nxt = sat_add(dropped_r, PAGES_W'(1));
            emit_status = STS_DROP;
          end else begin
            mem_we   = 1'b1;
            used_nxt = used_r + 1'b1;
          end
        end
        OP_RESERVE: begin
          emit = 1'b1;
          if (avail_w < least_w) begin
            emit_status = STS_EMPTY;
          end else begin
            resv_nxt   = resv_r + grant_w[CW-1:0];
            caller_nxt = (csum_w > WW'({CNT13_W{1'b1}})) ? {CNT13_W{1'b1}}
                                                         : csum_w[CNT13_W-1:0];
          end
        end
        OP_GETRES: begin
          if (!getres_ok) begin
            emit        = 1'b1;
            emit_status = STS_EMPTY;
          end else begin
            used_nxt   = used_m1;
            resv_nxt   = resv_r - 1'b1;
            caller_nxt = caller_r - 1'b1;
          end
        end
        OP_REGION: begin
          if (region_ne) begin
            pages_nxt = span[ADDR_W:PAGE_SH];
            pos_nxt   = start_a[ADDR_W-1:PAGE_SH];
          end else begin
            emit = 1'b1;
          end
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end

    // Finish a pop with the frame read from the stack top
    if (cmd.pop_emit) begin
      emit      = 1'b1;
      emit_page = rd_page;
    end

    // Push one region page per cycle, drop the rest once full
    if (cmd.walk) begin
      if (pages_r == '0) begin
        emit = 1'b1;
      end else if (full) begin
        emit        = 1'b1;
        emit_status = STS_DROP;
        dropped_nxt = sat_add(dropped_r, pages_r);
      end else begin
        mem_we    = 1'b1;
        wr_frame  = pos_r;
        used_nxt  = used_r + 1'b1;
        pos_nxt   = pos_r + 1'b1;
        pages_nxt = pages_r - 1'b1;
      end
    end
  end

  assign free_c   = used_nxt - resv_nxt;
  assign free_ext = {{CNT13_W{1'b0}}, free_c};
  assign resv_ext = {{CNT13_W{1'b0}}, resv_nxt};

  // Stack memory: at most one write per cycle, and a read of the top entry every cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[used_r[AW-1:0]] <= wr_ext[FRAME_BITS-1:0];
    end
    rdata_r <= mem[used_m1[AW-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      resv_r      <= '0;
      dropped_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      resv_r      <= resv_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= emit;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    addr_r   <= addr_nxt;
    len_r    <= len_nxt;
    least_r  <= least_nxt;
    ideal_r  <= ideal_nxt;
    caller_r <= caller_nxt;
    pages_r  <= pages_nxt;
    pos_r    <= pos_nxt;
    if (emit) begin
      status_r      <= emit_status;
      page_r        <= emit_page;
      caller_out_r  <= caller_nxt;
      free_r        <= free_ext[CNT13_W-1:0];
      resv_out_r    <= resv_ext[CNT13_W-1:0];
      dropped_out_r <= dropped_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_page_address     = page_r;
  assign out_caller_count_out = caller_out_r;
  assign out_free_pages       = free_r;
  assign out_reserved_pages   = resv_out_r;
  assign out_dropped_pages    = dropped_out_r;

  // Reserved pages never exceed stacked pages
  a_resv_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    resv_r <= used_r)
    else $error("reserved count exceeds stacked count");

  // Stack never grows past its depth
  a_used_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DEPTH_C)
    else $error("stack count beyond depth");

  // Results never come on adjacent cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held two cycles");

  // Dropped counter only moves up
  a_drop_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> dropped_r >= $past(dropped_r))
    else $error("dropped counter decreased");

endmodule

// ----- src/physical_page_stack_allocator.sv -----
// Channel   Handshake          Ports
// request   start & !busy      in_opcode, in_address, in_region_bytes,
//                              in_least_pages, in_ideal_pages, in_caller_count
// result    out_valid (1 cyc)  out_status, out_page_address, out_caller_count_out,
//                              out_free_pages, out_reserved_pages, out_dropped_pages
//
// Get and get-reserved go from accept to the next accept through decode, a read of
// the stack top from the page memory, and the result; put, reserve, failed pops,
// empty regions and unknown opcodes skip the read.
// Push region makes one memory write per page, after decode; pages that find the
// stack full are counted in one step.
// The result strobe shows in the cycle a new request may be accepted.
// Reset (rst_n low, synchronous) empties the stack and clears all counters.
// The receiver cannot stall: each result is valid for exactly one cycle.
module physical_page_stack_allocator #(
  parameter int STACK_DEPTH = 4096,
  parameter int FRAME_BITS  = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ppsa_pkg::OP_W-1:0]         in_opcode,
  input  logic [ppsa_pkg::ADDR_W-1:0]       in_address,
  input  logic [ppsa_pkg::ADDR_W-1:0]       in_region_bytes,
  input  logic [ppsa_pkg::CNT13_W-1:0]      in_least_pages,
  input  logic [ppsa_pkg::CNT13_W-1:0]      in_ideal_pages,
  input  logic [ppsa_pkg::CNT13_W-1:0]      in_caller_count,
  output logic                              out_valid,
  output logic [ppsa_pkg::STATUS_W-1:0]     out_status,
  output logic [ppsa_pkg::ADDR_W-1:0]       out_page_address,
  output logic [ppsa_pkg::CNT13_W-1:0]      out_caller_count_out,
  output logic [ppsa_pkg::CNT13_W-1:0]      out_free_pages,
  output logic [ppsa_pkg::CNT13_W-1:0]      out_reserved_pages,
  output logic [ppsa_pkg::ADDR_W-1:0]       out_dropped_pages
);
  import ppsa_pkg::*;

  ppsa_cmd_t cmd;
  ppsa_sts_t sts;

  // Sequence requests
  ppsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Stack, counters and result registers
  ppsa_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAME_BITS  (FRAME_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_opcode            (in_opcode),
    .in_address           (in_address),
    .in_region_bytes      (in_region_bytes),
    .in_least_pages       (in_least_pages),
    .in_ideal_pages       (in_ideal_pages),
    .in_caller_count      (in_caller_count),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_page_address     (out_page_address),
    .out_caller_count_out (out_caller_count_out),
    .out_free_pages       (out_free_pages),
    .out_reserved_pages   (out_reserved_pages),
    .out_dropped_pages    (out_dropped_pages)
  );

endmodule

// ----- tb/sv/physical_page_stack_allocator_tb.sv -----
`timescale 1ns / 1ps

module physical_page_stack_allocator_tb;
  import ppsa_pkg::*;

  localparam int unsigned DEPTH        = 4096;
  localparam int unsigned GAP_MAX      = 12;
  localparam int unsigned WATCHDOG     = 50000;
  localparam int unsigned SETTLE       = 20;
  localparam int unsigned CHUNKS       = 7;
  localparam int unsigned CHUNK_LEN    = 50;
  localparam int unsigned FLOOD_LEN    = 20;
  localparam logic [CNT13_W-1:0] CNT_MAX = '1;
  localparam logic [ADDR_W-1:0] DROP_MAX = '1;
  // Opcodes with no operation behind them
  localparam logic [OP_W-1:0] OP_NOP_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_NOP_LAST  = 3'd7;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  len;
    logic [CNT13_W-1:0] least;
    logic [CNT13_W-1:0] ideal;
    logic [CNT13_W-1:0] caller;
    int unsigned        gap;
    bit                 drain;
  } alloc_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page;
    logic [CNT13_W-1:0]  caller;
    logic [CNT13_W-1:0]  free;
    logic [CNT13_W-1:0]  rsv;
    logic [ADDR_W-1:0]   dropped;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0]     in_opcode = '0;
  logic [ADDR_W-1:0]   in_address = '0;
  logic [ADDR_W-1:0]   in_region_bytes = '0;
  logic [CNT13_W-1:0]  in_least_pages = '0;
  logic [CNT13_W-1:0]  in_ideal_pages = '0;
  logic [CNT13_W-1:0]  in_caller_count = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_page_address;
  logic [CNT13_W-1:0]  out_caller_count_out;
  logic [CNT13_W-1:0]  out_free_pages;
  logic [CNT13_W-1:0]  out_reserved_pages;
  logic [ADDR_W-1:0]   out_dropped_pages;

  physical_page_stack_allocator u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_address           (in_address),
    .in_region_bytes      (in_region_bytes),
    .in_least_pages       (in_least_pages),
    .in_ideal_pages       (in_ideal_pages),
    .in_caller_count      (in_caller_count),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_page_address     (out_page_address),
    .out_caller_count_out (out_caller_count_out),
    .out_free_pages       (out_free_pages),
    .out_reserved_pages   (out_reserved_pages),
    .out_dropped_pages    (out_dropped_pages)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow allocator state
  logic [FRAME20-1:0] frame_mem [DEPTH];
  int unsigned        stk_used = 0;
  int unsigned        stk_rsv = 0;
  logic [ADDR_W-1:0]  drop_total = '0;

  alloc_req_t  request_fifo[$];
  alloc_rsp_t  awaited[$];
  alloc_req_t  cur_req;
  bit          loaded = 1'b0;
  int unsigned gap_left = 0;
  bit          no_idle = 1'b0;
  int unsigned op_seen [8];
  int unsigned checked = 0;
  int unsigned fails = 0;
  int unsigned idle_cycles = 0;

  function automatic logic [ADDR_W-1:0] sat_add(logic [ADDR_W-1:0] acc, logic [63:0] n);
    logic [63:0] sum;
    sum = {32'd0, acc} + n;
    return (sum > {32'd0, DROP_MAX}) ? DROP_MAX : sum[ADDR_W-1:0];
  endfunction

  // Apply one request to the shadow stack and produce its result
  task automatic compute_alloc_result(input alloc_req_t r, output alloc_rsp_t e);
    logic [63:0] lo, hi, n;
    int unsigned avail, want, grant, cnt;
    e.status = STS_OK;
    e.page   = '0;
    e.caller = r.caller;
    avail    = stk_used - stk_rsv;
    case (r.op)
      OP_GET: begin
        if (avail == 0) begin
          e.status = STS_EMPTY;
        end else begin
          stk_used--;
          e.page = {frame_mem[stk_used], {PAGE_SH{1'b0}}};
        end
      end
      OP_PUT: begin
        if (stk_used >= DEPTH) begin
          drop_total = sat_add(drop_total, 64'd1);
          e.status = STS_DROP;
        end else begin
          frame_mem[stk_used] = r.addr[ADDR_W-1:PAGE_SH];
          stk_used++;
        end
      end
      OP_RESERVE: begin
        if (avail < 32'(r.least)) begin
          e.status = STS_EMPTY;
        end else begin
          want  = 32'((r.ideal < r.least) ? r.least : r.ideal);
          grant = (want < avail) ? want : avail;
          stk_rsv += grant;
          cnt = 32'(r.caller) + grant;
          e.caller = (cnt > 32'(CNT_MAX)) ? CNT_MAX : cnt[CNT13_W-1:0];
        end
      end
      OP_GETRES: begin
        if (r.caller == 0 || stk_rsv == 0 || stk_used == 0) begin
          e.status = STS_EMPTY;
        end else begin
          stk_used--;
          e.page = {frame_mem[stk_used], {PAGE_SH{1'b0}}};
          stk_rsv--;
          e.caller = r.caller - 1'b1;
        end
      end
      OP_REGION: begin
        // Round the start up and the end down to whole pages, clip at 4 GiB
        lo = ({32'd0, r.addr} + 64'hFFF) & ~64'hFFF;
        hi = {32'd0, r.addr} + {32'd0, r.len};
        if (hi > 64'h1_0000_0000) hi = 64'h1_0000_0000;
        hi = hi & ~64'hFFF;
        if (hi > lo) begin
          n = (hi - lo) >> PAGE_SH;
          while (n != 0 && stk_used < DEPTH) begin
            frame_mem[stk_used] = lo[ADDR_W-1:PAGE_SH];
            stk_used++;
            lo += 64'h1000;
            n--;
          end
          if (n != 0) begin
            drop_total = sat_add(drop_total, n);
            e.status = STS_DROP;
          end
        end
      end
      default: begin
      end
    endcase
    e.free    = CNT13_W'(stk_used - stk_rsv);
    e.rsv     = CNT13_W'(stk_rsv);
    e.dropped = drop_total;
  endtask

  function automatic alloc_req_t make_req(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                          logic [ADDR_W-1:0] len, logic [CNT13_W-1:0] least,
                                          logic [CNT13_W-1:0] ideal,
                                          logic [CNT13_W-1:0] caller);
    alloc_req_t r;
    r.op     = op;
    r.addr   = addr;
    r.len    = len;
    r.least  = least;
    r.ideal  = ideal;
    r.caller = caller;
    r.gap    = no_idle ? 0 : $urandom_range(0, GAP_MAX);
    r.drain  = 1'b0;
    return r;
  endfunction

  // Draw a request; draining mode favors pops over pushes
  function automatic alloc_req_t random_req(bit draining);
    int unsigned pick;
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  len;
    logic [CNT13_W-1:0] least, ideal, caller;
    pick = $urandom_range(0, 99);
    if (pick < (draining ? 10 : 30)) op = OP_PUT;
    else if (pick < 45) op = OP_GET;
    else if (pick < 60) op = OP_RESERVE;
    else if (pick < (draining ? 90 : 75)) op = OP_GETRES;
    else if (pick < 95) op = OP_REGION;
    else op = OP_W'($urandom_range(OP_NOP_LAST, OP_NOP_FIRST));

    pick = $urandom_range(0, 99);
    if (op != OP_REGION) len = $urandom();
    else if (pick < 75) len = $urandom_range(0, 8 * 4096);
    else if (pick < 95) len = $urandom_range(0, 64 * 4096);
    else len = $urandom();

    pick = $urandom_range(0, 99);
    if (pick < 70) least = CNT13_W'($urandom_range(0, 16));
    else if (pick < 85) least = CNT13_W'($urandom_range(0, 300));
    else least = CNT13_W'($urandom_range(0, CNT_MAX));

    pick = $urandom_range(0, 99);
    if (pick < 60) ideal = CNT13_W'($urandom_range(0, 24));
    else if (pick < 80) ideal = CNT13_W'($urandom_range(0, 500));
    else ideal = CNT13_W'($urandom_range(0, CNT_MAX));

    pick = $urandom_range(0, 99);
    if (pick < 20) caller = '0;
    else if (pick < 80) caller = CNT13_W'($urandom_range(1, 40));
    else caller = CNT13_W'($urandom_range(0, CNT_MAX));

    return make_req(op, $urandom(), len, least, ideal, caller);
  endfunction

  // Present requests in order, holding each one until it is taken
  always @(posedge clk) begin : drive
    alloc_rsp_t e;
    bit go;
    go = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        compute_alloc_result(cur_req, e);
        awaited.push_back(e);
        op_seen[cur_req.op]++;
        loaded = 1'b0;
      end
      if (!loaded && request_fifo.size() != 0) begin
        cur_req  = request_fifo.pop_front();
        gap_left = cur_req.gap;
        loaded   = 1'b1;
      end
      if (loaded) begin
        if (cur_req.drain && awaited.size() != 0) go = 1'b0;
        else if (gap_left != 0) gap_left--;
        else go = 1'b1;
      end
      start <= go;
      if (go) begin
        in_opcode       <= cur_req.op;
        in_address      <= cur_req.addr;
        in_region_bytes <= cur_req.len;
        in_least_pages  <= cur_req.least;
        in_ideal_pages  <= cur_req.ideal;
        in_caller_count <= cur_req.caller;
      end
    end
  end

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare each result with the oldest expectation; watch for a hang
  always @(posedge clk) begin : observe
    alloc_rsp_t e;
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: no request or result for %0d cycles", $time, WATCHDOG);
        $display("TB_ERROR");
        $finish;
      end else if (out_valid) begin
        if (awaited.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: expected none, actual status %0h page %0h",
                   $time, out_status, out_page_address);
        end else begin
          e = awaited.pop_front();
          checked++;
          check_field("status", ADDR_W'(e.status), ADDR_W'(out_status));
          check_field("page_address", e.page, out_page_address);
          check_field("caller_count_out", ADDR_W'(e.caller), ADDR_W'(out_caller_count_out));
          check_field("free_pages", ADDR_W'(e.free), ADDR_W'(out_free_pages));
          check_field("reserved_pages", ADDR_W'(e.rsv), ADDR_W'(out_reserved_pages));
          check_field("dropped_pages", e.dropped, out_dropped_pages);
        end
      end
    end
  end

  initial begin : stimulus
    alloc_req_t r;
    bit draining;

    // Directed: empty stack, alignment, clipping, reservation corners, full stack
    request_fifo.push_back(make_req(OP_GET, '0, '0, '0, '0, '0));
    request_fifo.push_back(make_req(OP_GETRES, '0, '0, '0, '0, 13'd5));
    request_fifo.push_back(make_req(OP_RESERVE, '0, '0, 13'd0, 13'd0, 13'd3));
    request_fifo.push_back(make_req(OP_RESERVE, '0, '0, 13'd1, 13'd1, 13'd0));
    request_fifo.push_back(make_req(OP_PUT, 32'h0000_0000, '1, '1, '1, '1));
    request_fifo.push_back(make_req(OP_PUT, 32'hFFFF_FFFF, '0, '0, '0, '0));
    request_fifo.push_back(make_req(OP_PUT, 32'h1234_5ABC, '0, '0, '0, '0));
    request_fifo.push_back(make_req(OP_GET, '0, '0, '0, '0, '0));
    request_fifo.push_back(make_req(OP_REGION, 32'h0000_1001, 32'h0000_3000, '0, '0, '0));
    request_fifo.push_back(make_req(OP_REGION, 32'h0000_5000, 32'h0000_0000, '0, '0, '0));
    request_fifo.push_back(make_req(OP_REGION, 32'hFFFF_E000, 32'hFFFF_FFFF, '0, '0, '0));
    request_fifo.push_back(make_req(OP_RESERVE, '0, '0, 13'd2, 13'd1, 13'd8190));
    request_fifo.push_back(make_req(OP_RESERVE, '0, '0, 13'd0, CNT_MAX, 13'd0));
    request_fifo.push_back(make_req(OP_GET, '0, '0, '0, '0, '0));
    request_fifo.push_back(make_req(OP_GETRES, '0, '0, '0, '0, 13'd0));
    request_fifo.push_back(make_req(OP_GETRES, '0, '0, '0, '0, CNT_MAX));
    request_fifo.push_back(make_req(OP_NOP_FIRST, '1, '1, '1, '1, '1));
    request_fifo.push_back(make_req(OP_NOP_LAST, '0, '0, '0, '0, 13'd77));
    request_fifo.push_back(make_req(OP_REGION, 32'h0000_0000, 32'hFFFF_FFFF, '0, '0, '0));
    request_fifo.push_back(make_req(OP_PUT, 32'hABCD_E000, '0, '0, '0, '0));
    request_fifo.push_back(make_req(OP_REGION, 32'h0010_0800, 32'h0000_4000, '0, '0, '0));
    request_fifo.push_back(make_req(OP_GETRES, '0, '0, '0, '0, 13'd1));
    request_fifo.push_back(make_req(OP_GET, '0, '0, '0, '0, '0));
    request_fifo.push_back(make_req(OP_RESERVE, '0, '0, CNT_MAX, CNT_MAX, 13'd4096));

    // Random chunks, each leaning toward filling or draining the stack
    for (int c = 0; c < CHUNKS; c++) begin
      draining = 1'($urandom_range(0, 1));
      no_idle  = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < CHUNK_LEN; i++) begin
        r = random_req(draining);
        // hold off once mid-run until every result is back
        if (c == CHUNKS / 2 && i == 0) r.drain = 1'b1;
        request_fifo.push_back(r);
      end
    end

    // Hit a full stack with whole-space regions to pile up the drop count
    no_idle = 1'b1;
    for (int i = 0; i < FLOOD_LEN; i++) begin
      r = make_req(OP_REGION, 32'h0000_0000, 32'hFFFF_FFFF, '0, '0, '0);
      if (i == 0) r.drain = 1'b1;
      request_fifo.push_back(r);
    end
    no_idle = 1'b0;
    for (int i = 0; i < 2 * CHUNK_LEN; i++) request_fifo.push_back(random_req(1'(i % 2)));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last request to be taken and its result to arrive
    while (request_fifo.size() != 0 || loaded || start) @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered requests: %0d get, %0d put, %0d reserve, %0d get-reserved,",
             op_seen[OP_GET], op_seen[OP_PUT], op_seen[OP_RESERVE], op_seen[OP_GETRES]);
    $display("  %0d region, %0d no-op", op_seen[OP_REGION],
             op_seen[OP_NOP_FIRST] + op_seen[OP_NOP_FIRST + 1] + op_seen[OP_NOP_LAST]);
    $display("Checked %0d results, drop count reached %0h, %0d mismatches",
             checked, drop_total, fails);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- physical_page_stack_allocator.f -----
src/ppsa_pkg.sv
src/ppsa_ctrl.sv
src/ppsa_dp.sv
src/physical_page_stack_allocator.sv
tb/sv/physical_page_stack_allocator_tb.sv
